[sv/dpds_pkg.sv]
// ---------------------------------------------------------------------------
// dpds_pkg: shared types and constants for the dual periodic deadline scheduler
// Payload structs, register indexes and controller/datapath command and status types.
// ---------------------------------------------------------------------------
`default_nettype none

package dpds_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int PERIOD_W    = 32;
    localparam int TIME_W      = 64;
    localparam int DIV_CNT_W   = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PERIOD   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTEXT_PERIOD = 8'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;
    localparam logic [TIME_W-1:0]   MAX_POS      = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic REQ_POLL    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [63:0] now_ms;
    } in_t;

    typedef struct packed {
        logic        fire_frame;
        logic        fire_context;
        logic [62:0] delay_to_next_ms;
        logic        frame_done;
        logic        context_done;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_sel_c;
        logic div_step;
        logic upd_f;
        logic upd_c;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fire_f;
        logic fire_c;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[sv/dpds_ctrl.sv]
// ---------------------------------------------------------------------------
// dpds_ctrl: scheduler sequencer
// Walks one item through evaluation, the remainder divisions and the result.
// ---------------------------------------------------------------------------
`default_nettype none

module dpds_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire dpds_pkg::status_t status,
    output dpds_pkg::cmd_t         cmd
);
    import dpds_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EVAL   = 7'b0000010,
        S_DIV_F  = 7'b0000100,
        S_UPD_F  = 7'b0001000,
        S_DIV_C  = 7'b0010000,
        S_UPD_C  = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (status.fire_f) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_F;
                end else if (status.fire_c) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel_c = 1'b1;
                    state_next    = S_DIV_C;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_DIV_F: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_UPD_F;
                end
            end
            S_UPD_F: begin
                cmd.upd_f = 1'b1;
                if (status.fire_c) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel_c = 1'b1;
                    state_next    = S_DIV_C;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_DIV_C: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_UPD_C;
                end
            end
            S_UPD_C: begin
                cmd.upd_c  = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/dpds_datapath.sv]
// ---------------------------------------------------------------------------
// dpds_datapath: schedule state, period registers and remainder divider
// Deadline skip uses now + (period - (now - deadline) mod period).
// ---------------------------------------------------------------------------
`default_nettype none

module dpds_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire dpds_pkg::in_t                        s_data,
    output dpds_pkg::out_t                            m_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    input  wire logic                                 cfg_valid,
    input  wire logic [dpds_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [dpds_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire dpds_pkg::cmd_t                       cmd,
    output dpds_pkg::status_t                         status
);
    import dpds_pkg::*;

    logic [TIME_W-1:0]    fdl_reg, cdl_reg;
    logic                 fexh_reg, cexh_reg;
    logic [PERIOD_W-1:0]  fper_reg, cper_reg;
    logic [TIME_W-1:0]    now_reg;
    logic                 fire_f_reg, fire_c_reg;
    logic [TIME_W-1:0]    q_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 sel_c_reg;
    out_t                 out_reg;
    logic                 out_valid_reg;

    logic [PERIOD_W-1:0]  fper_eff, cper_eff, per_sel;
    logic [PERIOD_W:0]    trial, trial_sub;
    logic [PERIOD_W-1:0]  rem_next;
    logic [PERIOD_W:0]    step_amt;
    logic [TIME_W:0]      new_sum;
    logic                 new_sat;
    logic [TIME_W-1:0]    new_dl;
    logic                 in_fire_f, in_fire_c;
    logic [TIME_W-1:0]    next_dl, diff;
    logic [62:0]          delay;
    logic                 cfg_hit;

    // effective periods, zero acts as one
    assign fper_eff = (fper_reg == '0) ? PERIOD_W'(1) : fper_reg;
    assign cper_eff = (cper_reg == '0) ? PERIOD_W'(1) : cper_reg;
    assign per_sel  = sel_c_reg ? cper_eff : fper_eff;

    // fire decision on the incoming item
    assign in_fire_f = (s_data.req_type == REQ_POLL) && !fexh_reg &&
                       !($signed(s_data.now_ms) < $signed(fdl_reg));
    assign in_fire_c = (s_data.req_type == REQ_POLL) && !cexh_reg &&
                       !($signed(s_data.now_ms) < $signed(cdl_reg));

    // one restoring remainder step
    assign trial     = {rem_reg, q_reg[TIME_W-1]};
    assign trial_sub = trial - {1'b0, per_sel};
    assign rem_next  = (trial >= {1'b0, per_sel}) ? trial_sub[PERIOD_W-1:0]
                                                  : trial[PERIOD_W-1:0];

    // skipped deadline with saturation check
    assign step_amt = {1'b0, per_sel} - {1'b0, rem_reg};
    assign new_sum  = {now_reg[TIME_W-1], now_reg} + {{(TIME_W-PERIOD_W){1'b0}}, step_amt};
    assign new_sat  = !new_sum[TIME_W] && new_sum[TIME_W-1];
    assign new_dl   = new_sat ? MAX_POS : new_sum[TIME_W-1:0];

    // delay to earliest live deadline
    always_comb begin
        if (fexh_reg) begin
            next_dl = cdl_reg;
        end else if (cexh_reg) begin
            next_dl = fdl_reg;
        end else if ($signed(cdl_reg) < $signed(fdl_reg)) begin
            next_dl = cdl_reg;
        end else begin
            next_dl = fdl_reg;
        end
        diff = next_dl - now_reg;
        if (fexh_reg && cexh_reg) begin
            delay = MAX_POS[62:0];
        end else if (!($signed(now_reg) < $signed(next_dl))) begin
            delay = '0;
        end else if (diff[TIME_W-1]) begin
            delay = MAX_POS[62:0];
        end else begin
            delay = diff[62:0];
        end
    end

    assign cfg_hit = cfg_valid &&
                     ((cfg_index == REG_FRAME_PERIOD) || (cfg_index == REG_CONTEXT_PERIOD));

    // schedule state and periods
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fdl_reg  <= '0;
            cdl_reg  <= '0;
            fexh_reg <= 1'b0;
            cexh_reg <= 1'b0;
            fper_reg <= PERIOD_RESET;
            cper_reg <= PERIOD_RESET;
        end else if (cfg_hit) begin
            if (cfg_index == REG_FRAME_PERIOD) begin
                fper_reg <= cfg_data;
            end else begin
                cper_reg <= cfg_data;
            end
            fdl_reg  <= '0;
            cdl_reg  <= '0;
            fexh_reg <= 1'b0;
            cexh_reg <= 1'b0;
        end else begin
            if (cmd.accept && s_data.req_type == REQ_RESTART) begin
                fdl_reg  <= s_data.now_ms;
                cdl_reg  <= s_data.now_ms;
                fexh_reg <= 1'b0;
                cexh_reg <= 1'b0;
            end
            if (cmd.upd_f) begin
                fdl_reg  <= new_dl;
                fexh_reg <= new_sat;
            end
            if (cmd.upd_c) begin
                cdl_reg  <= new_dl;
                cexh_reg <= new_sat;
            end
        end
    end

    // item capture and divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fire_f_reg <= 1'b0;
            fire_c_reg <= 1'b0;
            cnt_reg    <= '0;
            sel_c_reg  <= 1'b0;
        end else begin
            if (cmd.accept) begin
                now_reg    <= s_data.now_ms;
                fire_f_reg <= in_fire_f;
                fire_c_reg <= in_fire_c;
            end
            if (cmd.div_start) begin
                q_reg     <= now_reg - (cmd.div_sel_c ? cdl_reg : fdl_reg);
                rem_reg   <= '0;
                cnt_reg   <= '0;
                sel_c_reg <= cmd.div_sel_c;
            end else if (cmd.div_step) begin
                q_reg   <= {q_reg[TIME_W-2:0], 1'b0};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.fire_frame       <= fire_f_reg;
            out_reg.fire_context     <= fire_c_reg;
            out_reg.delay_to_next_ms <= delay;
            out_reg.frame_done       <= fexh_reg;
            out_reg.context_done     <= cexh_reg;
        end
    end

    assign m_data          = out_reg;
    assign m_valid         = out_valid_reg;
    assign status.fire_f   = fire_f_reg;
    assign status.fire_c   = fire_c_reg;
    assign status.div_last = (cnt_reg == {DIV_CNT_W{1'b1}});
    assign status.out_free = !out_valid_reg || m_ready;

endmodule

`default_nettype wire

[sv/dual_periodic_deadline_scheduler.sv]
// ---------------------------------------------------------------------------
// dual_periodic_deadline_scheduler: two periodic deadlines on one time base
//
//   channel   ports                               direction
//   input     s_valid / s_ready / s_data          item in (poll or restart)
//   result    m_valid / m_ready / m_data          one result per item
//   config    cfg_valid / cfg_ready / cfg_index / cfg_data   period writes
//
// A restart or a poll that fires nothing goes through evaluation and the result
// step only; each firing schedule adds a pass through the shared bit-serial
// remainder divider. One item is in work at a time; a finished result waits
// in the output register while the next item is taken. Reset is synchronous
// and needs no clearing pass; a held result stalls only the result step.
// ---------------------------------------------------------------------------
`default_nettype none

module dual_periodic_deadline_scheduler (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire dpds_pkg::in_t                      s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output dpds_pkg::out_t                          m_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dpds_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [dpds_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dpds_pkg::*;

    cmd_t    cmd;
    status_t status;

    // configuration must be written only while idle; the block does not enforce it
    assign cfg_ready = 1'b1;

    dpds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dpds_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

[tb/dual_periodic_deadline_scheduler_tb.sv]
// ---------------------------------------------------------------------------
// dual_periodic_deadline_scheduler_tb: self-checking bench for the scheduler
// Drives polls and restarts with random gaps and result back-pressure, predicts
// fire flags, delay and done flags per item, and checks every result transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module dual_periodic_deadline_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dpds_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 64'd2_000_000;
    localparam logic [63:0] SIGN_MSB = 64'h8000_0000_0000_0000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // scheduler mirror state
    logic [31:0] frame_period;
    logic [31:0] context_period;
    logic [63:0] frame_dl;
    logic [63:0] context_dl;
    logic frame_exh;
    logic context_exh;

    out_t expected_results[$];
    int errors = 0;
    longint unsigned cycles = 0;
    bit hold_off = 1'b0;

    dual_periodic_deadline_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("dual_periodic_deadline_scheduler_tb: FAIL");
            $finish;
        end
    end

    function automatic bit signed_lt(logic [63:0] a, logic [63:0] b);
        return (a ^ SIGN_MSB) < (b ^ SIGN_MSB);
    endfunction

    function automatic logic [63:0] period_of(logic [31:0] p);
        return (p == 32'd0) ? 64'd1 : {32'd0, p};
    endfunction

    // move a due deadline past now by whole periods, saturating
    function automatic void advance_deadline(inout logic [63:0] dl, inout logic exh,
                                             input logic [63:0] now,
                                             input logic [63:0] per);
        logic [63:0] whole;
        logic [63:0] headroom;
        whole = (now - dl) / per;
        headroom = (MAX_POS - dl) / per;
        if (whole >= headroom) begin
            dl = MAX_POS;
            exh = 1'b1;
        end else begin
            dl = dl + (whole + 64'd1) * per;
            exh = 1'b0;
        end
    endfunction

    function automatic out_t schedule_step(in_t item);
        out_t r;
        logic [63:0] now;
        logic [63:0] next;
        logic [63:0] gap;
        r = '0;
        now = item.now_ms;
        if (item.req_type == REQ_RESTART) begin
            frame_dl = now;
            context_dl = now;
            frame_exh = 1'b0;
            context_exh = 1'b0;
        end else begin
            if (!frame_exh && !signed_lt(now, frame_dl)) begin
                r.fire_frame = 1'b1;
                advance_deadline(frame_dl, frame_exh, now, period_of(frame_period));
            end
            if (!context_exh && !signed_lt(now, context_dl)) begin
                r.fire_context = 1'b1;
                advance_deadline(context_dl, context_exh, now,
                                 period_of(context_period));
            end
        end
        if (frame_exh && context_exh) begin
            r.delay_to_next_ms = MAX_POS[62:0];
        end else begin
            if (frame_exh) next = context_dl;
            else if (context_exh) next = frame_dl;
            else next = signed_lt(context_dl, frame_dl) ? context_dl : frame_dl;
            if (!signed_lt(now, next)) begin
                gap = 64'd0;
            end else begin
                gap = next - now;
                if (gap > MAX_POS) gap = MAX_POS;
            end
            r.delay_to_next_ms = gap[62:0];
        end
        r.frame_done = frame_exh;
        r.context_done = context_exh;
        return r;
    endfunction

    // valid stays up across back-to-back items and drops only before a gap
    task automatic send_item(logic kind, logic [63:0] now, bit no_gap = 0);
        in_t item;
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.req_type = kind;
        item.now_ms = now;
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!(s_valid && s_ready));
        expected_results.push_back(schedule_step(item));
    endtask

    // result receiver with random stalls
    initial begin
        int stall;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall != 0 || hold_off) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                while (hold_off) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // result checker
    always @(posedge aclk) begin
        out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data.fire_frame !== exp_r.fire_frame) begin
                    $error("fire_frame exp %0d got %0d", exp_r.fire_frame, m_data.fire_frame);
                    errors++;
                end
                if (m_data.fire_context !== exp_r.fire_context) begin
                    $error("fire_context exp %0d got %0d", exp_r.fire_context,
                           m_data.fire_context);
                    errors++;
                end
                if (m_data.delay_to_next_ms !== exp_r.delay_to_next_ms) begin
                    $error("delay_to_next_ms exp %0d got %0d", exp_r.delay_to_next_ms,
                           m_data.delay_to_next_ms);
                    errors++;
                end
                if (m_data.frame_done !== exp_r.frame_done) begin
                    $error("frame_done exp %0d got %0d", exp_r.frame_done, m_data.frame_done);
                    errors++;
                end
                if (m_data.context_done !== exp_r.context_done) begin
                    $error("context_done exp %0d got %0d", exp_r.context_done,
                           m_data.context_done);
                    errors++;
                end
            end
        end
    end

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    // period write; a write to a period register also clears the schedules
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_PERIOD) frame_period = value;
        if (idx == REG_FRAME_PERIOD || idx == REG_CONTEXT_PERIOD) begin
            if (idx == REG_CONTEXT_PERIOD) context_period = value;
            frame_dl = '0;
            context_dl = '0;
            frame_exh = 1'b0;
            context_exh = 1'b0;
        end
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        send_item(REQ_POLL, 64'd0);
        send_item(REQ_POLL, 64'd999);
        send_item(REQ_POLL, 64'd1000);
        send_item(REQ_POLL, 64'd5500);
        send_item(REQ_POLL, SIGN_MSB);
        send_item(REQ_POLL, MAX_POS);
        send_item(REQ_POLL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(REQ_RESTART, SIGN_MSB);
        send_item(REQ_POLL, MAX_POS);
        send_item(REQ_POLL, MAX_POS);
        send_item(REQ_RESTART, MAX_POS - 64'd1500);
        send_item(REQ_POLL, MAX_POS - 64'd1500);
        send_item(REQ_POLL, MAX_POS - 64'd200);
        send_item(REQ_POLL, MAX_POS);
        send_item(REQ_RESTART, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(REQ_POLL, 64'd12345);
        wait_idle();
        write_reg(REG_FRAME_PERIOD, 32'd0);
        write_reg(REG_CONTEXT_PERIOD, 32'hFFFF_FFFF);
        write_reg(8'd7, 32'd5);
        send_item(REQ_POLL, 64'd0);
        send_item(REQ_POLL, 64'd3);
        send_item(REQ_POLL, 64'h0000_0001_0000_0000);
        send_item(REQ_RESTART, SIGN_MSB);
        send_item(REQ_POLL, MAX_POS);
        send_item(REQ_POLL, 64'd42);
        wait_idle();
    endtask

    // mostly restart-then-ascending-poll sequences with random noise
    task automatic test_random(int count, logic [31:0] fp, logic [31:0] cp);
        logic [63:0] now;
        write_reg(REG_FRAME_PERIOD, fp);
        write_reg(REG_CONTEXT_PERIOD, cp);
        now = rand64();
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0: begin
                    now = rand64();
                    send_item(REQ_RESTART, now);
                end
                1: send_item(REQ_POLL, rand64());
                2: begin
                    now = MAX_POS - $urandom_range(0, 5000);
                    send_item(REQ_RESTART, now);
                end
                default: begin
                    now = now + $urandom_range(0, 3 * ((fp > 3000) ? 3000 : fp + 1));
                    send_item(REQ_POLL, now);
                end
            endcase
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (2500) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++) send_item(REQ_POLL, 64'd1000 * i, 1);
        join
        wait_idle();
    endtask

    initial begin
        frame_period = PERIOD_RESET;
        context_period = PERIOD_RESET;
        frame_dl = '0;
        context_dl = '0;
        frame_exh = 1'b0;
        context_exh = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(450, 32'd1000, 32'd1000);
        test_random(450, 32'd1, 32'd7);
        test_random(450, 32'd333, 32'd0);
        test_random(200, 32'hFFFF_FFFF, 32'd50);
        test_random(250, $urandom_range(1, 2000), $urandom());
        test_backpressure();
        if (errors == 0) begin
            $display("dual_periodic_deadline_scheduler_tb: PASS");
        end else begin
            $display("dual_periodic_deadline_scheduler_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

[dual_periodic_deadline_scheduler.f]
sv/dpds_pkg.sv
sv/dpds_ctrl.sv
sv/dpds_datapath.sv
sv/dual_periodic_deadline_scheduler.sv
tb/dual_periodic_deadline_scheduler_tb.sv
